// ===== src/wsrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrm_pkg
// Shared constants, types and controller/datapath interface structs for the
// windowed success rate monitor.
// ----------------------------------------------------------------------------
package wsrm_pkg;

  localparam int BUCKETS       = 288;
  localparam int RING_BITS     = 9;
  localparam int RING_LOW_BITS = 5;
  localparam int RING_HIGH     = BUCKETS / (2 ** RING_LOW_BITS);
  localparam int REM_BITS      = 4;
  localparam int SLOT_BITS     = 32;
  // 64 is 1 mod RING_HIGH, so six-bit digits of the slot quotient fold
  localparam int FOLD_BITS     = 6;
  localparam int MOD_STEPS     = 2;
  localparam int MOD_CNT_BITS  = 2;
  localparam int COUNT_BITS    = 16;
  localparam int SUM_BITS      = 25;
  localparam int WIN_BITS      = 9;
  localparam int RATIO_BITS    = 8;
  localparam int CFG_BITS      = 9;
  localparam int CFG_IDX_BITS  = 2;
  localparam int PROD_BITS     = SUM_BITS + RATIO_BITS;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [WIN_BITS-1:0]   RECENT_WINDOW_RST = 9'd8;
  localparam logic [WIN_BITS-1:0]   LONG_WINDOW_RST   = 9'd16;
  localparam logic [RATIO_BITS-1:0] RECENT_RATIO_RST  = 8'd5;
  localparam logic [RATIO_BITS-1:0] LONG_RATIO_RST    = 8'd2;

  typedef logic [RING_BITS-1:0] ring_idx_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RECENT_WINDOW,
    REG_LONG_WINDOW,
    REG_RECENT_RATIO,
    REG_LONG_RATIO
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOD,
    ST_ADV,
    ST_CLEAR,
    ST_REC_RD,
    ST_REC_WR,
    ST_SUM_INIT,
    ST_SUM,
    ST_MULT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic mod_step;
    logic adv_start;
    logic clear_step;
    logic rec_read;
    logic rec_write;
    logic sum_start;
    logic sum_step;
    logic mult_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic cnt_zero;
    logic sum_done;
    logic is_query;
  } dp_status_t;

endpackage

// ===== src/windowed_success_rate_monitor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_success_rate_monitor_core
// Ring of time-slot buckets with success and attempt counts; records
// attempts and answers probe queries over a recent and a longer window.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   input    | in_valid / in_stall | cmd, slot_now, success
//   output   | out_valid/out_stall | probe_needed, recent_/long_ successes,
//            |                     | recent_/long_ attempts
//   config   | cfg_wr_en           | cfg_index, cfg_data
//
// one transaction at a time: the accept cycle, slot modulo and setup, one cycle per
// cleared bucket (up to 288), then a bucket read and write for a record, or sum setup,
// the window sum, the multiply and the output load for a query, plus any wait for
// the output register; the bucket memory sets the pace
// after reset a sweep clears the bucket memory with in_stall high
// a finished result sits in the output register while the next input
// transaction is taken; a query ends only once that register is free
// ----------------------------------------------------------------------------
module windowed_success_rate_monitor_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [wsrm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [wsrm_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cmd,
  input  logic [wsrm_pkg::SLOT_BITS-1:0]    slot_now,
  input  logic                              success,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              probe_needed,
  output logic [wsrm_pkg::SUM_BITS-1:0]     recent_successes,
  output logic [wsrm_pkg::SUM_BITS-1:0]     recent_attempts,
  output logic [wsrm_pkg::SUM_BITS-1:0]     long_successes,
  output logic [wsrm_pkg::SUM_BITS-1:0]     long_attempts
);
  import wsrm_pkg::*;

  dp_cmd_t    ctl;
  dp_status_t status;

  wsrm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .status    (status)
  );

  wsrm_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .status           (status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .slot_now         (slot_now),
    .success          (success),
    .probe_needed     (probe_needed),
    .recent_successes (recent_successes),
    .recent_attempts  (recent_attempts),
    .long_successes   (long_successes),
    .long_attempts    (long_attempts)
  );

endmodule

// ===== src/wsrm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrm_datapath
// Bucket memory, slot modulo unit, ring pointer, window accumulators,
// threshold multipliers, configuration registers and result register.
// ----------------------------------------------------------------------------
module wsrm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  wsrm_pkg::dp_cmd_t             ctl,
  output wsrm_pkg::dp_status_t          status,
  input  logic                          cfg_wr_en,
  input  logic [wsrm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [wsrm_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          cmd,
  input  logic [wsrm_pkg::SLOT_BITS-1:0] slot_now,
  input  logic                          success,
  output logic                          probe_needed,
  output logic [wsrm_pkg::SUM_BITS-1:0] recent_successes,
  output logic [wsrm_pkg::SUM_BITS-1:0] recent_attempts,
  output logic [wsrm_pkg::SUM_BITS-1:0] long_successes,
  output logic [wsrm_pkg::SUM_BITS-1:0] long_attempts
);
  import wsrm_pkg::*;

  localparam ring_idx_t       LAST_IDX  = ring_idx_t'(BUCKETS - 1);
  localparam logic [WIN_BITS-1:0] WIN_MAX = WIN_BITS'(BUCKETS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam int QUOT_BITS     = SLOT_BITS - RING_LOW_BITS;
  localparam int FOLD_SUM_BITS = FOLD_BITS + 3;

  logic [WIN_BITS-1:0]   recent_window;
  logic [WIN_BITS-1:0]   long_window;
  logic [RATIO_BITS-1:0] recent_ratio;
  logic [RATIO_BITS-1:0] long_ratio;

  logic                  cmd_r;
  logic [SLOT_BITS-1:0]  now_r;
  logic                  success_r;

  logic [QUOT_BITS-1:0]     quot;
  logic [FOLD_SUM_BITS-1:0] fold_s1;
  logic [FOLD_BITS:0]       fold_s2;
  logic [FOLD_BITS-1:0]     fold_s3;
  logic [FOLD_BITS-1:0]     fold_r;
  logic [FOLD_BITS-1:0]     red1;
  logic [FOLD_BITS-1:0]     red2;
  logic [REM_BITS-1:0]      rem_next;
  logic [REM_BITS-1:0]      rem;
  logic [MOD_CNT_BITS-1:0]  mod_cnt;
  ring_idx_t                now_idx;

  logic [SLOT_BITS-1:0]  last_slot;
  ring_idx_t             last_idx;
  logic [SLOT_BITS-1:0]  slot_gap;
  logic [WIN_BITS-1:0]   clear_len;

  ring_idx_t             ptr;
  logic [WIN_BITS-1:0]   cnt;
  logic [WIN_BITS-1:0]   k;
  logic [WIN_BITS-1:0]   rlen;
  logic [WIN_BITS-1:0]   llen;
  logic [WIN_BITS-1:0]   rlen_next;
  logic [WIN_BITS-1:0]   llen_next;
  logic                  sum_issue;
  logic                  rd_v;
  logic                  tag_r;
  logic                  tag_l;

  logic [SUM_BITS-1:0]   rs;
  logic [SUM_BITS-1:0]   ra;
  logic [SUM_BITS-1:0]   ls;
  logic [SUM_BITS-1:0]   la;
  logic [PROD_BITS-1:0]  rprod;
  logic [PROD_BITS-1:0]  lprod;

  logic [2*COUNT_BITS-1:0] mem [BUCKETS];
  logic                    rd_en;
  ring_idx_t               rd_addr;
  logic [2*COUNT_BITS-1:0] rd_data;
  logic                    wr_en;
  ring_idx_t               wr_addr;
  logic [2*COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0]   rd_succ;
  logic [COUNT_BITS-1:0]   rd_att;

  function automatic ring_idx_t ring_inc(input ring_idx_t i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic ring_idx_t ring_dec(input ring_idx_t i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_window <= RECENT_WINDOW_RST;
      long_window   <= LONG_WINDOW_RST;
      recent_ratio  <= RECENT_RATIO_RST;
      long_ratio    <= LONG_RATIO_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_RECENT_WINDOW: recent_window <= cfg_data;
        REG_LONG_WINDOW:   long_window   <= cfg_data;
        REG_RECENT_RATIO:  recent_ratio  <= cfg_data[RATIO_BITS-1:0];
        REG_LONG_RATIO:    long_ratio    <= cfg_data[RATIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_r     <= cmd;
      now_r     <= slot_now;
      success_r <= success;
    end
  end

  // slot mod ring size: digit fold of the upper slot bits, then
  // three compare and subtract steps on the folded value
  assign quot    = now_r[SLOT_BITS-1:RING_LOW_BITS];
  assign fold_s1 = FOLD_SUM_BITS'(quot[FOLD_BITS-1:0]) +
                   FOLD_SUM_BITS'(quot[2*FOLD_BITS-1:FOLD_BITS]) +
                   FOLD_SUM_BITS'(quot[3*FOLD_BITS-1:2*FOLD_BITS]) +
                   FOLD_SUM_BITS'(quot[4*FOLD_BITS-1:3*FOLD_BITS]) +
                   FOLD_SUM_BITS'(quot[QUOT_BITS-1:4*FOLD_BITS]);
  assign fold_s2 = (FOLD_BITS + 1)'(fold_s1[FOLD_BITS-1:0]) +
                   (FOLD_BITS + 1)'(fold_s1[FOLD_SUM_BITS-1:FOLD_BITS]);
  assign fold_s3 = fold_s2[FOLD_BITS-1:0] + FOLD_BITS'(fold_s2[FOLD_BITS]);

  assign red1     = (fold_r >= FOLD_BITS'(4 * RING_HIGH)) ?
                    fold_r - FOLD_BITS'(4 * RING_HIGH) : fold_r;
  assign red2     = (red1 >= FOLD_BITS'(2 * RING_HIGH)) ?
                    red1 - FOLD_BITS'(2 * RING_HIGH) : red1;
  assign rem_next = (red2 >= FOLD_BITS'(RING_HIGH)) ?
                    REM_BITS'(red2 - FOLD_BITS'(RING_HIGH)) : REM_BITS'(red2);
  assign now_idx  = ring_idx_t'({rem, now_r[RING_LOW_BITS-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
    end else if (ctl.load_item) begin
      mod_cnt <= MOD_CNT_BITS'(MOD_STEPS);
    end else if (ctl.mod_step) begin
      mod_cnt <= mod_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mod_step) begin
      fold_r <= fold_s3;
      rem    <= rem_next;
    end
  end

  // slot advance
  assign slot_gap  = now_r - last_slot;
  assign clear_len = (now_r <= last_slot) ? '0 :
                     (slot_gap > SLOT_BITS'(BUCKETS)) ? WIN_MAX : slot_gap[WIN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_slot <= '0;
      last_idx  <= '0;
    end else if (ctl.adv_start) begin
      last_slot <= now_r;
      last_idx  <= now_idx;
    end
  end

  // window lengths clamped to the ring
  assign rlen_next = (recent_window > WIN_MAX) ? WIN_MAX : recent_window;
  assign llen_next = (long_window > WIN_MAX) ? WIN_MAX : long_window;
  assign sum_issue = ctl.sum_step && (cnt != '0);

  // ring pointer and count, reset starts the clearing sweep over the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      cnt  <= WIN_MAX;
      rd_v <= 1'b0;
    end else begin
      rd_v <= sum_issue;
      if (ctl.adv_start) begin
        ptr <= ring_inc(last_idx);
        cnt <= clear_len;
      end else if (ctl.clear_step && (cnt != '0)) begin
        ptr <= ring_inc(ptr);
        cnt <= cnt - 1'b1;
      end else if (ctl.sum_start) begin
        ptr <= now_idx;
        cnt <= (rlen_next > llen_next) ? rlen_next : llen_next;
      end else if (sum_issue) begin
        ptr <= ring_dec(ptr);
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_start) begin
      k    <= '0;
      rlen <= rlen_next;
      llen <= llen_next;
    end else if (sum_issue) begin
      k     <= k + 1'b1;
      tag_r <= k < rlen;
      tag_l <= k < llen;
    end
  end

  // bucket memory ports
  assign rd_succ = rd_data[2*COUNT_BITS-1:COUNT_BITS];
  assign rd_att  = rd_data[COUNT_BITS-1:0];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr;
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = '0;
    if (ctl.rec_read) begin
      rd_en   = 1'b1;
      rd_addr = now_idx;
    end else if (sum_issue) begin
      rd_en = 1'b1;
    end
    if (ctl.clear_step && (cnt != '0)) begin
      wr_en = 1'b1;
    end else if (ctl.rec_write) begin
      wr_en   = 1'b1;
      wr_addr = now_idx;
      wr_data = {(success_r && (rd_succ != COUNT_MAX)) ? rd_succ + 1'b1 : rd_succ,
                 (rd_att != COUNT_MAX) ? rd_att + 1'b1 : rd_att};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // window accumulators
  always_ff @(posedge clk) begin
    if (ctl.sum_start) begin
      rs <= '0;
      ra <= '0;
      ls <= '0;
      la <= '0;
    end else if (rd_v) begin
      if (tag_r) begin
        rs <= rs + SUM_BITS'(rd_succ);
        ra <= ra + SUM_BITS'(rd_att);
      end
      if (tag_l) begin
        ls <= ls + SUM_BITS'(rd_succ);
        la <= la + SUM_BITS'(rd_att);
      end
    end
  end

  // threshold products
  always_ff @(posedge clk) begin
    if (ctl.mult_load) begin
      rprod <= PROD_BITS'(rs) * PROD_BITS'(recent_ratio);
      lprod <= PROD_BITS'(ls) * PROD_BITS'(long_ratio);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      probe_needed     <= ((ra != '0) && (rprod <= PROD_BITS'(ra))) ||
                          ((la != '0) && (lprod <= PROD_BITS'(la)));
      recent_successes <= rs;
      recent_attempts  <= ra;
      long_successes   <= ls;
      long_attempts    <= la;
    end
  end

  assign status.mod_done = (mod_cnt == '0);
  assign status.cnt_zero = (cnt == '0);
  assign status.sum_done = (cnt == '0) && !rd_v;
  assign status.is_query = (cmd_r == CMD_QUERY);

endmodule

// ===== src/wsrm_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrm_controller
// Sequencer for ring clearing, record update and window query, plus the
// input stall and output valid handshake.
// ----------------------------------------------------------------------------
module wsrm_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wsrm_pkg::dp_cmd_t    ctl,
  input  wsrm_pkg::dp_status_t status
);
  import wsrm_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.cnt_zero) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_MOD;
      end
      ST_MOD: begin
        if (status.mod_done) state_next = ST_ADV;
      end
      ST_ADV: state_next = ST_CLEAR;
      ST_CLEAR: begin
        if (status.cnt_zero) begin
          state_next = status.is_query ? ST_SUM_INIT : ST_REC_RD;
        end
      end
      ST_REC_RD:   state_next = ST_REC_WR;
      ST_REC_WR:   state_next = ST_IDLE;
      ST_SUM_INIT: state_next = ST_SUM;
      ST_SUM: begin
        if (status.sum_done) state_next = ST_MULT;
      end
      ST_MULT: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_INIT:     ctl.clear_step = 1'b1;
      ST_IDLE:     ctl.load_item  = in_valid;
      ST_MOD:      ctl.mod_step   = !status.mod_done;
      ST_ADV:      ctl.adv_start  = 1'b1;
      ST_CLEAR:    ctl.clear_step = 1'b1;
      ST_REC_RD:   ctl.rec_read   = 1'b1;
      ST_REC_WR:   ctl.rec_write  = 1'b1;
      ST_SUM_INIT: ctl.sum_start  = 1'b1;
      ST_SUM:      ctl.sum_step   = 1'b1;
      ST_MULT:     ctl.mult_load  = 1'b1;
      ST_OUT:      ctl.out_load   = out_free;
      default:     ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed success rate monitor. A short table
// of transactions covers slot wrap, backward slots, large jumps and the
// window edges. Random phases follow, each with its own register setup, with
// random stalls on both channels outside one calm phase. Each probe report is
// checked against a bench bucket-ring predictor, or a typed table report.
// ----------------------------------------------------------------------------
module tb_top;
  import wsrm_pkg::*;

  localparam int          DRAIN_CYCLES   = 700;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          LONG_HOLD      = 2000;
  localparam int          PHASE_ITEMS    = 80;
  localparam int          NUM_PHASES     = 6;
  localparam int          NUM_ROWS       = 18;
  localparam logic [31:0] BUCKETS_U      = BUCKETS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam longint unsigned SUM_MAX = (64'd1 << SUM_BITS) - 64'd1;

  typedef struct packed {
    logic                probe;
    logic [SUM_BITS-1:0] rs;
    logic [SUM_BITS-1:0] ra;
    logic [SUM_BITS-1:0] ls;
    logic [SUM_BITS-1:0] la;
  } health_report_t;

  typedef struct packed {
    logic           c;
    logic [31:0]    slot;
    logic           ok;
    logic           typed;
    health_report_t rep;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]   cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  cmd;
  logic [SLOT_BITS-1:0]  slot_now;
  logic                  success;
  logic                  out_valid;
  logic                  out_stall;
  logic                  probe_needed;
  logic [SUM_BITS-1:0]   recent_successes;
  logic [SUM_BITS-1:0]   recent_attempts;
  logic [SUM_BITS-1:0]   long_successes;
  logic [SUM_BITS-1:0]   long_attempts;

  logic [COUNT_BITS-1:0] succ_m [BUCKETS];
  logic [COUNT_BITS-1:0] att_m  [BUCKETS];
  logic [31:0]           last_slot_m;
  logic [WIN_BITS-1:0]   recent_len;
  logic [WIN_BITS-1:0]   long_len;
  logic [RATIO_BITS-1:0] recent_ratio_cfg;
  logic [RATIO_BITS-1:0] long_ratio_cfg;

  health_report_t expected_reports [$];
  health_report_t want_rep;
  stim_row_t      directed_rows [NUM_ROWS];
  int unsigned    mismatches;
  bit             calm;
  bit             long_hold_req;
  int             idle_cycles;

  windowed_success_rate_monitor_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .slot_now         (slot_now),
    .success          (success),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .probe_needed     (probe_needed),
    .recent_successes (recent_successes),
    .recent_attempts  (recent_attempts),
    .long_successes   (long_successes),
    .long_attempts    (long_attempts)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ring_idx_t slot_bucket(logic [31:0] s);
    return ring_idx_t'(s % BUCKETS_U);
  endfunction

  function automatic logic [SUM_BITS-1:0] clip_sum(longint unsigned v);
    return (v > SUM_MAX) ? SUM_MAX[SUM_BITS-1:0] : v[SUM_BITS-1:0];
  endfunction

  function automatic void age_out_buckets(logic [31:0] now);
    logic [31:0] slot_gap;
    int          n;
    ring_idx_t   idx;
    if (now > last_slot_m) begin
      slot_gap = now - last_slot_m;
      n = (slot_gap > BUCKETS_U) ? BUCKETS : int'(slot_gap);
      for (int k = 1; k <= n; k++) begin
        idx = slot_bucket(last_slot_m + 32'(k));
        succ_m[idx] = '0;
        att_m[idx]  = '0;
      end
    end
    last_slot_m = now;
  endfunction

  function automatic void tally_window(logic [31:0] now, logic [WIN_BITS-1:0] len,
                                       output longint unsigned s,
                                       output longint unsigned a);
    int base;
    int span;
    int idx;
    base = int'(slot_bucket(now));
    span = (int'(len) > BUCKETS) ? BUCKETS : int'(len);
    s = 0;
    a = 0;
    for (int k = 0; k < span; k++) begin
      idx = (base + BUCKETS - k) % BUCKETS;
      s += succ_m[idx];
      a += att_m[idx];
    end
  endfunction

  function automatic void predict_item(logic c, logic [31:0] now, logic ok,
                                       output bit has_rep,
                                       output health_report_t rep);
    ring_idx_t       idx;
    longint unsigned rs;
    longint unsigned ra;
    longint unsigned ls;
    longint unsigned la;
    age_out_buckets(now);
    rep = '0;
    has_rep = 1'b0;
    if (c == CMD_RECORD) begin
      idx = slot_bucket(now);
      if (ok && succ_m[idx] != COUNT_MAX) succ_m[idx] = succ_m[idx] + 1'b1;
      if (att_m[idx] != COUNT_MAX) att_m[idx] = att_m[idx] + 1'b1;
    end else begin
      tally_window(now, recent_len, rs, ra);
      tally_window(now, long_len, ls, la);
      rep.probe = (ra > 0 && rs * longint'(recent_ratio_cfg) <= ra) ||
                  (la > 0 && ls * longint'(long_ratio_cfg) <= la);
      rep.rs = clip_sum(rs);
      rep.ra = clip_sum(ra);
      rep.ls = clip_sum(ls);
      rep.la = clip_sum(la);
      has_rep = 1'b1;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  function automatic logic [31:0] next_slot(logic [31:0] s);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return s;
    if (r < 85) return s + $urandom_range(1, 3);
    if (r < 92) return s + $urandom_range(4, 40);
    if (r < 96) return s - $urandom_range(1, 20);
    if (r < 98) return s + $urandom_range(289, 100000);
    return $urandom();
  endfunction

  task automatic send_transaction(logic c, logic [31:0] s, logic ok, logic typed,
                                  health_report_t typed_rep);
    bit             has_rep;
    health_report_t rep;
    int             gap;
    in_valid <= 1'b1;
    cmd      <= c;
    slot_now <= s;
    success  <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(c, s, ok, has_rep, rep);
    if (has_rep) expected_reports = {expected_reports, (typed ? typed_rep : rep)};
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_RECENT_WINDOW: recent_len = data[WIN_BITS-1:0];
      REG_LONG_WINDOW:   long_len = data[WIN_BITS-1:0];
      REG_RECENT_RATIO:  recent_ratio_cfg = data[RATIO_BITS-1:0];
      REG_LONG_RATIO:    long_ratio_cfg = data[RATIO_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_windows(logic [CFG_BITS-1:0] rw, logic [CFG_BITS-1:0] lw,
                                 logic [CFG_BITS-1:0] rr, logic [CFG_BITS-1:0] lr);
    write_reg(REG_RECENT_WINDOW, rw);
    write_reg(REG_LONG_WINDOW, lw);
    write_reg(REG_RECENT_RATIO, rr);
    write_reg(REG_LONG_RATIO, lr);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // response side stall pattern
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        automatic int len = pick_gap();
        if (len == 0) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("report transaction with no expectation pending");
        mismatches++;
      end else begin
        want_rep = expected_reports.pop_front();
        if (probe_needed !== want_rep.probe) begin
          $error("probe_needed: expected %0d, got %0d", want_rep.probe, probe_needed);
          mismatches++;
        end
        if (recent_successes !== want_rep.rs) begin
          $error("recent_successes: expected %0d, got %0d", want_rep.rs, recent_successes);
          mismatches++;
        end
        if (recent_attempts !== want_rep.ra) begin
          $error("recent_attempts: expected %0d, got %0d", want_rep.ra, recent_attempts);
          mismatches++;
        end
        if (long_successes !== want_rep.ls) begin
          $error("long_successes: expected %0d, got %0d", want_rep.ls, long_successes);
          mismatches++;
        end
        if (long_attempts !== want_rep.la) begin
          $error("long_attempts: expected %0d, got %0d", want_rep.la, long_attempts);
          mismatches++;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [31:0] cur_slot;
    logic        c;
    int          p_succ;
    rst       <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    cmd       <= CMD_RECORD;
    slot_now  <= '0;
    success   <= 1'b0;
    mismatches = 0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    for (int i = 0; i < BUCKETS; i++) begin
      succ_m[i] = '0;
      att_m[i]  = '0;
    end
    last_slot_m      = '0;
    recent_len       = RECENT_WINDOW_RST;
    long_len         = LONG_WINDOW_RST;
    recent_ratio_cfg = RECENT_RATIO_RST;
    long_ratio_cfg   = LONG_RATIO_RST;

    directed_rows = '{
      '{CMD_QUERY,  32'd0,          1'b0, 1'b1, '0},
      '{CMD_RECORD, 32'd0,          1'b1, 1'b0, '0},
      '{CMD_RECORD, 32'd0,          1'b0, 1'b0, '0},
      '{CMD_QUERY,  32'd0,          1'b1, 1'b1, '{1'b1, 25'd1, 25'd2, 25'd1, 25'd2}},
      '{CMD_RECORD, 32'd3,          1'b1, 1'b0, '0},
      '{CMD_RECORD, 32'd3,          1'b1, 1'b0, '0},
      '{CMD_QUERY,  32'd3,          1'b0, 1'b0, '0},
      '{CMD_RECORD, 32'd20,         1'b0, 1'b0, '0},
      '{CMD_QUERY,  32'd20,         1'b0, 1'b0, '0},
      '{CMD_RECORD, 32'd10,         1'b1, 1'b0, '0},
      '{CMD_QUERY,  32'd10,         1'b0, 1'b0, '0},
      '{CMD_QUERY,  32'd2000,       1'b0, 1'b1, '0},
      '{CMD_RECORD, 32'hFFFF_FFFF,  1'b1, 1'b0, '0},
      '{CMD_RECORD, 32'hFFFF_FFFF,  1'b1, 1'b0, '0},
      '{CMD_QUERY,  32'hFFFF_FFFF,  1'b0, 1'b0, '0},
      '{CMD_QUERY,  32'd0,          1'b1, 1'b0, '0},
      '{CMD_RECORD, 32'd5,          1'b0, 1'b0, '0},
      '{CMD_QUERY,  32'd5,          1'b0, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_transaction(directed_rows[i].c, directed_rows[i].slot, directed_rows[i].ok,
                       directed_rows[i].typed, directed_rows[i].rep);
    end
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: program_windows(9'd0, 9'd511, 9'd0, 9'd255);
        1: program_windows(9'd288, 9'd1, 9'h1FF, 9'd1);
        default: begin
          program_windows(
            CFG_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(1, 24)),
            CFG_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(1, 48)),
            CFG_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(1, 8)),
            CFG_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(1, 8)));
        end
      endcase
      calm = (ph == 4);
      long_hold_req = (ph == 2);
      p_succ = $urandom_range(5, 95);
      cur_slot = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                             : $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) begin
          // sender holds until all reports are back
          in_valid <= 1'b0;
          @(posedge clk);
          while (expected_reports.size() != 0) @(posedge clk);
        end
        cur_slot = next_slot(cur_slot);
        c = ($urandom_range(0, 99) < 30) ? CMD_QUERY : CMD_RECORD;
        send_transaction(c, cur_slot, ($urandom_range(0, 99) < p_succ), 1'b0, '0);
      end
      settle();
    end

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
